FILE: src/sqh_pkg.sv
// ----------------------------------------------------------------------------
// sqh_pkg
// Shared types and constants for the segment versus quad hull test.
// ----------------------------------------------------------------------------
package sqh_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int NUM_PTS         = 6;
  localparam int PT_IDX_W        = 3;
  localparam int HULL_IDX_W      = 2;

  localparam logic [PT_IDX_W-1:0] PT_S = 3'd4;
  localparam logic [PT_IDX_W-1:0] PT_E = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_B00, ST_B01, ST_B10, ST_B11, ST_BUILD,
    ST_EDGE, ST_EDGE_W,
    ST_REV, ST_REV_W,
    ST_FOW, ST_FOW_W,
    ST_T1, ST_T1_W, ST_T2, ST_T2_W,
    ST_T3, ST_T3_W, ST_T4, ST_T4_W,
    ST_T5, ST_T5_W, ST_T6, ST_T6_W,
    ST_OUT
  } state_t;

  // request to the cross unit: three point indexes
  typedef struct packed {
    logic                start;
    logic [PT_IDX_W-1:0] ia;
    logic [PT_IDX_W-1:0] ib;
    logic [PT_IDX_W-1:0] ic;
  } xcmd_t;

  typedef struct packed {
    logic done;
    logic pos;
    logic neg;
  } xsts_t;

endpackage

FILE: src/sqh_cross.sv
// ----------------------------------------------------------------------------
// sqh_cross
// Sign of the extended cross product of three stored points, multicycle.
// ----------------------------------------------------------------------------
module sqh_cross import sqh_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic [NUM_PTS*COORD_WIDTH-1:0] px,
  input  logic [NUM_PTS*COORD_WIDTH-1:0] py,
  input  logic [NUM_PTS-1:0]          pinf,
  input  xcmd_t                       cmd,
  output xsts_t                       sts
);
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_WIDTH-1:0] xs [NUM_PTS];
  logic signed [COORD_WIDTH-1:0] ys [NUM_PTS];
  logic [NUM_PTS-1:0] infs;

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_PTS; i++) begin
        xs[i] <= px[i*COORD_WIDTH +: COORD_WIDTH];
        ys[i] <= py[i*COORD_WIDTH +: COORD_WIDTH];
      end
      infs <= pinf;
    end
  end

  // operand select
  logic signed [DW-1:0] x1, y1, x2, y2;
  logic                 negate, zero;
  logic                 ai, bi, ci;
  logic signed [DW-1:0] ax, ay, bx, by, cx, cy;

  always_comb begin
    ai = infs[cmd.ia];
    bi = infs[cmd.ib];
    ci = infs[cmd.ic];
    ax = DW'(xs[cmd.ia]); ay = DW'(ys[cmd.ia]);
    bx = DW'(xs[cmd.ib]); by = DW'(ys[cmd.ib]);
    cx = DW'(xs[cmd.ic]); cy = DW'(ys[cmd.ic]);
    negate = 1'b0;
    zero   = 1'b0;
    if (!ai) begin
      x1 = bi ? bx : bx - ax;
      y1 = bi ? by : by - ay;
      x2 = ci ? cx : cx - ax;
      y2 = ci ? cy : cy - ay;
    end else if (bi) begin
      x1 = ax; y1 = ay; x2 = bx; y2 = by;
      zero = ci;
    end else begin
      x1 = ax; y1 = ay;
      x2 = ci ? cx : cx - bx;
      y2 = ci ? cy : cy - by;
      negate = 1'b1;
    end
  end

  // stage 1: register operands, stage 2: products, stage 3: compare
  logic signed [DW-1:0] r_x1, r_y1, r_x2, r_y2;
  logic                 r_neg, r_zero;
  logic signed [PW-1:0] p, q;
  logic                 p_neg, p_zero;
  logic [2:0]           busy;
  logic                 res_pos, res_neg;

  always_ff @(posedge clk) begin
    r_x1 <= x1; r_y1 <= y1; r_x2 <= x2; r_y2 <= y2;
    r_neg <= negate; r_zero <= zero;
    p <= PW'(r_x1) * PW'(r_y2);
    q <= PW'(r_x2) * PW'(r_y1);
    p_neg <= r_neg; p_zero <= r_zero;
    if (p_zero || p == q) begin
      res_pos <= 1'b0; res_neg <= 1'b0;
    end else begin
      res_pos <= (p > q) ^ p_neg;
      res_neg <= (p < q) ^ p_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
    end else begin
      busy <= {busy[1:0], cmd.start};
    end
  end

  assign sts.done = busy[2];
  assign sts.pos  = res_pos;
  assign sts.neg  = res_neg;
endmodule

FILE: src/sqh_ctrl.sv
// ----------------------------------------------------------------------------
// sqh_ctrl
// Sequencer: hull build, edge search, walks and end-point tests.
// ----------------------------------------------------------------------------
module sqh_ctrl import sqh_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  load,
  output xcmd_t cmd,
  input  xsts_t sts,
  output logic  out_valid,
  input  logic  out_stall,
  output logic  meets_hull
);
  state_t state, state_next;
  logic [PT_IDX_W-1:0] h [4];
  logic [PT_IDX_W-1:0] h_next [4];
  logic [2:0] n, n_next;
  logic [HULL_IDX_W-1:0] i, a, b, i_next, a_next, b_next;
  logic [2:0] k, k_next;
  logic s00p, s00n, s01p, s01n, s10p, s10n, s11p, s11n;
  logic res, res_next;
  logic sv_en;
  logic out_load;

  function automatic logic [HULL_IDX_W-1:0] inc(logic [HULL_IDX_W-1:0] v, logic [2:0] m);
    logic [2:0] t;
    t = {1'b0, v} + 3'd1;
    return (t == m) ? '0 : t[HULL_IDX_W-1:0];
  endfunction

  function automatic logic [HULL_IDX_W-1:0] dec(logic [HULL_IDX_W-1:0] v, logic [2:0] m);
    logic [2:0] t;
    t = (v == '0) ? m - 3'd1 : {1'b0, v} - 3'd1;
    return t[HULL_IDX_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
    if (out_load) meets_hull <= res;
    h <= h_next; n <= n_next; i <= i_next; a <= a_next; b <= b_next;
    k <= k_next; res <= res_next;
    if (sts.done) begin
      unique case (state)
        ST_B00:  begin s00p <= sts.pos; s00n <= sts.neg; end
        ST_B01:  begin s01p <= sts.pos; s01n <= sts.neg; end
        ST_B10:  begin s10p <= sts.pos; s10n <= sts.neg; end
        ST_B11:  begin s11p <= sts.pos; s11n <= sts.neg; end
        default: ;
      endcase
    end
  end

  assign sv_en = 1'b0;

  logic same0, same1;
  logic [HULL_IDX_W-1:0] c, d;
  assign same0 = (s00p && s01p) || (s00n && s01n);
  assign same1 = (s10p && s11p) || (s10n && s11n);
  assign c = inc(a, n);
  assign d = inc(c, n);

  always_comb begin
    state_next = state;
    h_next = h; n_next = n; i_next = i; a_next = a; b_next = b;
    k_next = k; res_next = res;
    in_stall = 1'b1; load = 1'b0; out_load = 1'b0;
    cmd = '{start: 1'b0, ia: '0, ib: '0, ic: '0};
    unique case (state)
      ST_IDLE: begin
        in_stall = sv_en;
        k_next = 3'd0;
        if (in_valid) begin
          load = 1'b1;
          state_next = ST_B00;
        end
      end
      ST_B00: begin
        cmd = '{start: (k == 3'd0), ia: 3'd0, ib: 3'd1, ic: 3'd2};
        k_next = 3'd1;
        if (sts.done) begin k_next = 3'd0; state_next = ST_B01; end
      end
      ST_B01: begin
        cmd = '{start: (k == 3'd0), ia: 3'd0, ib: 3'd1, ic: 3'd3};
        k_next = 3'd1;
        if (sts.done) begin k_next = 3'd0; state_next = ST_B10; end
      end
      ST_B10: begin
        cmd = '{start: (k == 3'd0), ia: 3'd2, ib: 3'd3, ic: 3'd0};
        k_next = 3'd1;
        if (sts.done) begin k_next = 3'd0; state_next = ST_B11; end
      end
      ST_B11: begin
        cmd = '{start: (k == 3'd0), ia: 3'd2, ib: 3'd3, ic: 3'd1};
        k_next = 3'd1;
        if (sts.done) begin k_next = 3'd0; state_next = ST_BUILD; end
      end
      ST_BUILD: begin
        if (same0 && same1) begin
          h_next[0] = s00p ? 3'd0 : 3'd1; h_next[1] = s00p ? 3'd1 : 3'd0;
          h_next[2] = s10p ? 3'd2 : 3'd3; h_next[3] = s10p ? 3'd3 : 3'd2;
          n_next = 3'd4;
        end else if (same0) begin
          h_next[0] = s00p ? 3'd0 : 3'd1; h_next[1] = s00p ? 3'd1 : 3'd0;
          h_next[2] = (s00p ? s11p : s10p) ? 3'd2 : 3'd3;
          h_next[3] = 3'd0;
          n_next = 3'd3;
        end else if (same1) begin
          h_next[0] = s10p ? 3'd2 : 3'd3; h_next[1] = s10p ? 3'd3 : 3'd2;
          h_next[2] = (s10p ? s01p : s00p) ? 3'd0 : 3'd1;
          h_next[3] = 3'd0;
          n_next = 3'd3;
        end else begin
          h_next[0] = 3'd0; h_next[1] = s00p ? 3'd3 : 3'd2;
          h_next[2] = 3'd1; h_next[3] = s00p ? 3'd2 : 3'd3;
          n_next = 3'd4;
        end
        i_next = '0;
        res_next = 1'b1;
        state_next = ST_EDGE;
      end
      ST_EDGE: begin
        cmd = '{start: 1'b1, ia: h[i], ib: h[inc(i, n)], ic: PT_S};
        state_next = ST_EDGE_W;
      end
      ST_EDGE_W: begin
        if (sts.done) begin
          if (sts.neg) begin
            a_next = i; b_next = inc(i, n); k_next = 3'd0;
            state_next = ST_REV;
          end else if ({1'b0, i} == n - 3'd1) begin
            res_next = 1'b1; state_next = ST_OUT;
          end else begin
            i_next = inc(i, n); state_next = ST_EDGE;
          end
        end
      end
      ST_REV: begin
        if (k == n) begin
          k_next = 3'd0; state_next = ST_FOW;
        end else begin
          cmd = '{start: 1'b1, ia: h[dec(a, n)], ib: h[a], ic: PT_S};
          state_next = ST_REV_W;
        end
      end
      ST_REV_W: begin
        if (sts.done) begin
          if (sts.neg) begin
            a_next = dec(a, n); k_next = k + 3'd1; state_next = ST_REV;
          end else begin
            k_next = 3'd0; state_next = ST_FOW;
          end
        end
      end
      ST_FOW: begin
        if (k == n) begin
          state_next = ST_T1;
        end else begin
          cmd = '{start: 1'b1, ia: PT_S, ib: h[b], ic: h[inc(b, n)]};
          state_next = ST_FOW_W;
        end
      end
      ST_FOW_W: begin
        if (sts.done) begin
          if (sts.neg) begin
            b_next = inc(b, n); k_next = k + 3'd1; state_next = ST_FOW;
          end else begin
            state_next = ST_T1;
          end
        end
      end
      ST_T1: begin
        cmd = '{start: 1'b1, ia: PT_S, ib: h[a], ic: PT_E};
        state_next = ST_T1_W;
      end
      ST_T1_W: if (sts.done) begin
        if (sts.pos) begin res_next = 1'b0; state_next = ST_OUT; end
        else state_next = ST_T2;
      end
      ST_T2: begin
        cmd = '{start: 1'b1, ia: PT_S, ib: h[b], ic: PT_E};
        state_next = ST_T2_W;
      end
      ST_T2_W: if (sts.done) begin
        if (sts.neg) begin res_next = 1'b0; state_next = ST_OUT; end
        else if (b == c) state_next = ST_T3;
        else state_next = ST_T4;
      end
      ST_T3: begin
        cmd = '{start: 1'b1, ia: h[b], ib: h[a], ic: PT_E};
        state_next = ST_T3_W;
      end
      ST_T3_W: if (sts.done) begin
        res_next = !sts.pos; state_next = ST_OUT;
      end
      ST_T4: begin
        cmd = '{start: 1'b1, ia: h[c], ib: h[a], ic: PT_E};
        state_next = ST_T4_W;
      end
      ST_T4_W: if (sts.done) begin
        if (sts.pos) begin res_next = 1'b0; state_next = ST_OUT; end
        else state_next = ST_T5;
      end
      ST_T5: begin
        cmd = '{start: 1'b1, ia: h[b], ib: (d == b) ? h[c] : h[d], ic: PT_E};
        state_next = ST_T5_W;
      end
      ST_T5_W: if (sts.done) begin
        if (sts.pos) begin res_next = 1'b0; state_next = ST_OUT; end
        else state_next = ST_T6;
      end
      ST_T6: begin
        cmd = '{start: 1'b1, ia: h[d], ib: h[c], ic: PT_E};
        state_next = ST_T6_W;
      end
      ST_T6_W: if (sts.done) begin
        res_next = !sts.pos; state_next = ST_OUT;
      end
      ST_OUT: begin
        // output register free, or emptied at this edge
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

FILE: src/segment_vs_quad_hull_test.sv
// ----------------------------------------------------------------------------
// segment_vs_quad_hull_test
// Reports whether segment start..end meets the hull built from c1..c4.
// ----------------------------------------------------------------------------
// channel | signals                                  | direction
// input   | in_valid, in_stall, c1..c4, seg_*, flags | request in
// output  | out_valid, out_stall, meets_hull         | request out
//
// One request at a time. Every cross test runs through one shared three-stage
// cross unit (operand select, 33x33 products, compare).
// How long a request takes, from acceptance to a valid result and to the next
// acceptance, is set by the number of edge, walk and side tests the sequencer
// issues on that unit.
// Reset (rst, synchronous) returns the sequencer to idle.
// The result holds in its output register while out_stall is high; the next
// request is taken meanwhile and its result waits until the register frees.
// ----------------------------------------------------------------------------
module segment_vs_quad_hull_test import sqh_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] c1_xy,
  input  logic [63:0] c2_xy,
  input  logic [63:0] c3_xy,
  input  logic [63:0] c4_xy,
  input  logic [63:0] seg_start_xy,
  input  logic [63:0] seg_end_xy,
  input  logic [5:0]  at_infinity_flags,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        meets_hull
);
  logic [NUM_PTS*COORD_WIDTH-1:0] px, py;
  logic  load;
  xcmd_t cmd;
  xsts_t sts;

  // low COORD_WIDTH bits of each half are the coordinate
  assign px = {seg_end_xy[32 +: COORD_WIDTH], seg_start_xy[32 +: COORD_WIDTH],
               c4_xy[32 +: COORD_WIDTH], c3_xy[32 +: COORD_WIDTH],
               c2_xy[32 +: COORD_WIDTH], c1_xy[32 +: COORD_WIDTH]};
  assign py = {seg_end_xy[COORD_WIDTH-1:0], seg_start_xy[COORD_WIDTH-1:0],
               c4_xy[COORD_WIDTH-1:0], c3_xy[COORD_WIDTH-1:0],
               c2_xy[COORD_WIDTH-1:0], c1_xy[COORD_WIDTH-1:0]};

  sqh_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross (
    .clk(clk), .rst(rst), .load(load), .px(px), .py(py),
    .pinf(at_infinity_flags), .cmd(cmd), .sts(sts)
  );

  sqh_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .load(load), .cmd(cmd), .sts(sts), .out_valid(out_valid),
    .out_stall(out_stall), .meets_hull(meets_hull)
  );
endmodule
